// ----- rtl/core/segment_pair_intersect_macros.svh -----
// ---------------------------------------------------------------------------
// segment pair intersection assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_INTERSECT_MACROS_SVH
`define SEGMENT_PAIR_INTERSECT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition must never hold outside reset
`define SPI_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define SPI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define SPI_ASSERT_NEVER(label, clk, rst, cond)
`define SPI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/spi_pkg.sv -----
// ---------------------------------------------------------------------------
// segment pair intersection package
// widths and the job word passed from the front to the back
// ---------------------------------------------------------------------------
`default_nettype none
package spi_pkg;
   localparam int COORD_BITS  = 32;
   localparam int T_FRAC_BITS = 16;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int PARAM_W     = T_FRAC_BITS + 1;
   localparam int DIV_STAGES  = T_FRAC_BITS + 1;
   localparam int SCALE_W     = DIFF_W + PARAM_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W  = 8 * COORD_BITS;
   localparam int RSP_FLD_W   = 2 * PARAM_W + 2 * COORD_BITS;
   localparam int RSP_DATA_W  = ((RSP_FLD_W + 7) / 8) * 8;

   typedef struct packed {
      logic                         ok;
      logic        [CROSS_W-1:0]    num1;
      logic        [CROSS_W-1:0]    num2;
      logic        [CROSS_W-1:0]    den;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [DIFF_W-1:0]     rx;
      logic signed [DIFF_W-1:0]     ry;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;
endpackage
`default_nettype wire

// ----- rtl/core/spi_front.sv -----
// ---------------------------------------------------------------------------
// segment pair intersection front
// differences, cross products and the in-range classification
// ---------------------------------------------------------------------------
`default_nettype none
module spi_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire logic                                in_valid,
   input  wire logic [spi_pkg::REQ_DATA_W-1:0]      in_data,
   output logic                                     job_valid,
   output spi_pkg::job_type                         job
);
   localparam int CB = spi_pkg::COORD_BITS;
   localparam int DW = spi_pkg::DIFF_W;
   localparam int PW = spi_pkg::PROD_W;
   localparam int XW = spi_pkg::CROSS_W;

   logic signed [CB-1:0] a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y;
   assign a1x = in_data[0*CB +: CB];
   assign a1y = in_data[1*CB +: CB];
   assign b1x = in_data[2*CB +: CB];
   assign b1y = in_data[3*CB +: CB];
   assign a2x = in_data[4*CB +: CB];
   assign a2y = in_data[5*CB +: CB];
   assign b2x = in_data[6*CB +: CB];
   assign b2y = in_data[7*CB +: CB];

   logic [3:0] vld_ff;
   logic signed [CB-1:0] s1_ax_ff, s1_ay_ff, s2_ax_ff, s2_ay_ff, s3_ax_ff, s3_ay_ff;
   logic signed [DW-1:0] s1_rx_ff, s1_ry_ff, s1_sx_ff, s1_sy_ff, s1_dx_ff, s1_dy_ff;
   logic signed [DW-1:0] s2_rx_ff, s2_ry_ff, s3_rx_ff, s3_ry_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [XW-1:0] den_ff, n1_ff, n2_ff;
   spi_pkg::job_type     job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: edge vectors
         s1_ax_ff <= a1x;
         s1_ay_ff <= a1y;
         s1_rx_ff <= DW'(b1x) - DW'(a1x);
         s1_ry_ff <= DW'(b1y) - DW'(a1y);
         s1_sx_ff <= DW'(b2x) - DW'(a2x);
         s1_sy_ff <= DW'(b2y) - DW'(a2y);
         s1_dx_ff <= DW'(a2x) - DW'(a1x);
         s1_dy_ff <= DW'(a2y) - DW'(a1y);
         // stage 2: partial products
         s2_ax_ff <= s1_ax_ff;
         s2_ay_ff <= s1_ay_ff;
         s2_rx_ff <= s1_rx_ff;
         s2_ry_ff <= s1_ry_ff;
         p0_ff    <= s1_rx_ff * s1_sy_ff;
         p1_ff    <= s1_ry_ff * s1_sx_ff;
         p2_ff    <= s1_dx_ff * s1_sy_ff;
         p3_ff    <= s1_dy_ff * s1_sx_ff;
         p4_ff    <= s1_dx_ff * s1_ry_ff;
         p5_ff    <= s1_dy_ff * s1_rx_ff;
         // stage 3: cross products
         s3_ax_ff <= s2_ax_ff;
         s3_ay_ff <= s2_ay_ff;
         s3_rx_ff <= s2_rx_ff;
         s3_ry_ff <= s2_ry_ff;
         den_ff   <= XW'(p0_ff) - XW'(p1_ff);
         n1_ff    <= XW'(p2_ff) - XW'(p3_ff);
         n2_ff    <= XW'(p4_ff) - XW'(p5_ff);
         // stage 4: classification
         job_ff   <= job_in;
      end
   end

   logic [XW-1:0] an1, an2, ad;
   logic          sgn1_ok, sgn2_ok;

   always_comb begin
      an1     = n1_ff[XW-1] ? XW'(-n1_ff) : XW'(n1_ff);
      an2     = n2_ff[XW-1] ? XW'(-n2_ff) : XW'(n2_ff);
      ad      = den_ff[XW-1] ? XW'(-den_ff) : XW'(den_ff);
      sgn1_ok = (n1_ff == '0) || (n1_ff[XW-1] == den_ff[XW-1]);
      sgn2_ok = (n2_ff == '0) || (n2_ff[XW-1] == den_ff[XW-1]);
      job_in.ok      = (den_ff != '0) && sgn1_ok && sgn2_ok && (ad >= an1) && (ad >= an2);
      job_in.num1    = an1;
      job_in.num2    = an2;
      job_in.den     = ad;
      job_in.start_x = s3_ax_ff;
      job_in.start_y = s3_ay_ff;
      job_in.rx      = s3_rx_ff;
      job_in.ry      = s3_ry_ff;
   end

   assign job_valid = vld_ff[3];
   assign job       = job_ff;
endmodule
`default_nettype wire

// ----- rtl/core/spi_queue.sv -----
// ---------------------------------------------------------------------------
// segment pair intersection job queue
// short register queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none
module spi_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire spi_pkg::job_type push_job,
   input  wire logic         pop,
   output spi_pkg::job_type  head,
   output spi_pkg::qstat_type stat
);
   localparam int PW = spi_pkg::QPTR_W;
   localparam int CW = spi_pkg::QCNT_W;

   spi_pkg::job_type entry_ff [spi_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = CW'(cnt_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   assign head       = entry_ff[rd_ff];
   assign stat.full  = (cnt_ff == CW'(spi_pkg::QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
endmodule
`default_nettype wire

// ----- rtl/core/spi_back.sv -----
// ---------------------------------------------------------------------------
// segment pair intersection back
// bit-per-stage quotients, then the crossing point and the result word
// ---------------------------------------------------------------------------
`default_nettype none
module spi_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           in_valid,
   input  wire spi_pkg::job_type               job,
   output logic                                out_valid,
   output logic                                out_hit,
   output logic [spi_pkg::RSP_DATA_W-1:0]      out_data
);
   localparam int NS = spi_pkg::DIV_STAGES;
   localparam int XW = spi_pkg::CROSS_W;
   localparam int QW = spi_pkg::PARAM_W;
   localparam int CB = spi_pkg::COORD_BITS;
   localparam int SW = spi_pkg::SCALE_W;
   localparam int TF = spi_pkg::T_FRAC_BITS;

   logic [NS-1:0]    vld_ff;
   spi_pkg::job_type st_ff [NS];
   spi_pkg::job_type st_in [NS];
   logic [QW-1:0]    q1_ff [NS];
   logic [QW-1:0]    q2_ff [NS];
   logic [QW-1:0]    q1_in [NS];
   logic [QW-1:0]    q2_in [NS];

   for (genvar i = 0; i < NS; i++) begin : g_div
      spi_pkg::job_type src;
      logic [QW-1:0]    sq1, sq2;
      logic [XW-1:0]    r1, r2;
      logic             ge1, ge2;
      always_comb begin
         if (i == 0) begin
            src = job;
            sq1 = '0;
            sq2 = '0;
            r1  = job.num1;
            r2  = job.num2;
         end else begin
            src = st_ff[(i == 0) ? 0 : i - 1];
            sq1 = q1_ff[(i == 0) ? 0 : i - 1];
            sq2 = q2_ff[(i == 0) ? 0 : i - 1];
            // remainder stays below the divisor, so the shift cannot overflow
            r1  = {src.num1[XW-2:0], 1'b0};
            r2  = {src.num2[XW-2:0], 1'b0};
         end
         ge1       = (r1 >= src.den);
         ge2       = (r2 >= src.den);
         st_in[i]      = src;
         st_in[i].num1 = ge1 ? XW'(r1 - src.den) : r1;
         st_in[i].num2 = ge2 ? XW'(r2 - src.den) : r2;
         q1_in[i]  = {sq1[QW-2:0], ge1};
         q2_in[i]  = {sq2[QW-2:0], ge2};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[i] <= st_in[i];
            q1_ff[i] <= q1_in[i];
            q2_ff[i] <= q2_in[i];
         end
      end
   end

   logic                 m_vld_ff, o_vld_ff;
   logic                 m_ok_ff;
   logic [QW-1:0]        m_q1_ff, m_q2_ff;
   logic signed [CB-1:0] m_ax_ff, m_ay_ff;
   logic signed [SW-1:0] m_px_ff, m_py_ff;
   logic                 o_hit_ff;
   logic [spi_pkg::RSP_DATA_W-1:0] o_data_ff, o_data_in;
   logic signed [SW-1:0] tq;
   logic [CB-1:0]        cx, cy;

   assign tq = SW'($signed({1'b0, q1_ff[NS-1]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         m_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff   <= {vld_ff[NS-2:0], in_valid};
         m_vld_ff <= vld_ff[NS-1];
         o_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ok_ff   <= st_ff[NS-1].ok;
         m_q1_ff   <= q1_ff[NS-1];
         m_q2_ff   <= q2_ff[NS-1];
         m_ax_ff   <= st_ff[NS-1].start_x;
         m_ay_ff   <= st_ff[NS-1].start_y;
         m_px_ff   <= SW'(st_ff[NS-1].rx) * tq;
         m_py_ff   <= SW'(st_ff[NS-1].ry) * tq;
         o_hit_ff  <= m_ok_ff;
         o_data_ff <= o_data_in;
      end
   end

   always_comb begin
      // floor shift of the scaled delta, kept to coordinate width
      cx = CB'(m_ax_ff + m_px_ff[TF +: CB]);
      cy = CB'(m_ay_ff + m_py_ff[TF +: CB]);
      o_data_in = '0;
      if (m_ok_ff) begin
         o_data_in[0 +: QW]           = m_q1_ff;
         o_data_in[QW +: QW]          = m_q2_ff;
         o_data_in[2*QW +: CB]        = cx;
         o_data_in[2*QW + CB +: CB]   = cy;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_hit   = o_hit_ff;
   assign out_data  = o_data_ff;
endmodule
`default_nettype wire

// ----- rtl/core/segment_pair_intersect.sv -----
// path: req word to rsp word through 4 front stages, the queue register,
// 17 one-bit-per-stage quotient stages, one multiply and one output stage
// throughput: one segment pair per cycle while rsp is taken and the queue has room
// reset: synchronous active-high reset empties the pipes and the 4-entry queue
// ---------------------------------------------------------------------------
// segment pair intersection top level
// front pipe, job queue and quotient back end on stream channels
// ---------------------------------------------------------------------------
`default_nettype none
`include "segment_pair_intersect_macros.svh"
module segment_pair_intersect (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  wire logic [spi_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // first_param, second_param, cross_x, cross_y, zero pad
   output logic [spi_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // hit
   output logic                                   rsp_tuser
);
   localparam logic [spi_pkg::PARAM_W-1:0] T_ONE = spi_pkg::PARAM_W'(1 << spi_pkg::T_FRAC_BITS);

   logic               front_adv, back_adv, job_valid, push, pop;
   spi_pkg::job_type   job, head;
   spi_pkg::qstat_type qstat;
   logic [spi_pkg::PARAM_W-1:0] first_param;

   assign front_adv  = !qstat.full;
   assign req_tready = front_adv;
   assign push       = front_adv && job_valid;
   assign back_adv   = !rsp_tvalid || rsp_tready;
   assign pop        = back_adv && !qstat.empty;
   assign first_param = rsp_tdata[spi_pkg::PARAM_W-1:0];

   spi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (front_adv),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .job_valid (job_valid),
      .job       (job)
   );

   spi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .stat     (qstat)
   );

   spi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (back_adv),
      .in_valid  (pop),
      .job       (head),
      .out_valid (rsp_tvalid),
      .out_hit   (rsp_tuser),
      .out_data  (rsp_tdata)
   );

   `SPI_ASSERT_NEVER(a_push_full, clock, reset, push && qstat.full)
   `SPI_ASSERT_NEVER(a_full_empty, clock, reset, qstat.full && qstat.empty)
   `SPI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `SPI_ASSERT_IMPLY(a_param_max, clock, reset, rsp_tvalid && rsp_tuser, first_param <= T_ONE)
endmodule
`default_nettype wire

// ----- dv/tb_segment_pair_intersect.sv -----
// ---------------------------------------------------------------------------
// segment pair intersection testbench
// directed table then random segment pairs, checked against an exact predictor
// ---------------------------------------------------------------------------
`default_nettype none
module tb_segment_pair_intersect;
   localparam int PW = spi_pkg::PARAM_W;
   localparam int CB = spi_pkg::COORD_BITS;
   localparam int TF = spi_pkg::T_FRAC_BITS;
   localparam int RQW = spi_pkg::REQ_DATA_W;
   localparam int RSW = spi_pkg::RSP_DATA_W;
   localparam int LIMIT_CYCLES = 400000;
   localparam int N_RANDOM = 500;
   localparam int N_DIRECTED = 16;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      logic          hit;
      logic [PW-1:0] t1;
      logic [PW-1:0] t2;
      coord_type     cx;
      coord_type     cy;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RQW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSW-1:0] rsp_tdata;
   logic rsp_tuser;

   crossing_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   bit sending_done = 1'b0;
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;
   bit pressure_done = 1'b0;

   segment_pair_intersect DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic logic signed [127:0] widen(input coord_type v);
      return 128'(v);
   endfunction

   // exact Q1.16 quotient when num/den lies in [0,1]
   function automatic bit param_of(input logic signed [127:0] num,
                                   input logic signed [127:0] den,
                                   output logic [PW-1:0] q);
      logic signed [127:0] an, ad;
      logic [159:0] wide;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = '0;
      if (num != 0 && ((num < 0) != (den < 0))) return 0;
      if (an > ad) return 0;
      wide = (160'(an) << TF) / 160'(ad);
      q = wide[PW-1:0];
      return 1;
   endfunction

   function automatic crossing_type predict_crossing(input logic [RQW-1:0] w);
      logic signed [127:0] ax1, ay1, bx1, by1, ax2, ay2, bx2, by2;
      logic signed [127:0] rx, ry, sx, sy, dx, dy, den, n1, n2, px, py;
      crossing_type c;
      ax1 = widen(coord_type'(w[0*CB +: CB]));
      ay1 = widen(coord_type'(w[1*CB +: CB]));
      bx1 = widen(coord_type'(w[2*CB +: CB]));
      by1 = widen(coord_type'(w[3*CB +: CB]));
      ax2 = widen(coord_type'(w[4*CB +: CB]));
      ay2 = widen(coord_type'(w[5*CB +: CB]));
      bx2 = widen(coord_type'(w[6*CB +: CB]));
      by2 = widen(coord_type'(w[7*CB +: CB]));
      rx = bx1 - ax1; ry = by1 - ay1;
      sx = bx2 - ax2; sy = by2 - ay2;
      dx = ax2 - ax1; dy = ay2 - ay1;
      den = rx * sy - ry * sx;
      n1 = dx * sy - dy * sx;
      n2 = dx * ry - dy * rx;
      c = '0;
      if (den != 0 && param_of(n1, den, c.t1) && param_of(n2, den, c.t2)) begin
         c.hit = 1'b1;
         px = (rx * 128'($signed({1'b0, c.t1}))) >>> TF;
         py = (ry * 128'($signed({1'b0, c.t1}))) >>> TF;
         c.cx = coord_type'(ax1 + px);
         c.cy = coord_type'(ay1 + py);
      end else begin
         c = '0;
      end
      return c;
   endfunction

   function automatic logic [RQW-1:0] pack_pair(input coord_type a1x, a1y, b1x, b1y,
                                                input coord_type a2x, a2y, b2x, b2y);
      return {b2y, b2x, a2y, a2x, b1y, b1x, a1y, a1x};
   endfunction

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 64)) - 32);
         2: return coord_type'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom_range(0, 1) ? coord_type'(32'h7fffffff - $urandom_range(0, 3))
                                             : coord_type'(32'h80000000 + $urandom_range(0, 3));
      endcase
   endfunction

   // a pair built to cross: segments through a shared point, random spans
   function automatic logic [RQW-1:0] crossing_pair(input int span);
      coord_type px, py, ux, uy, vx, vy;
      px = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      py = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      ux = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      uy = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      vx = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      vy = coord_type'($signed($urandom_range(0, 2 * span)) - span);
      return pack_pair(px - ux, py - uy, px + ux, py + uy, px - vx, py - vy, px + vx, py + vy);
   endfunction

   logic [RQW-1:0] pair_table[N_DIRECTED];
   crossing_type typed_table[N_DIRECTED];
   bit typed_valid[N_DIRECTED];

   localparam coord_type CMAX = 32'sh7fffffff;
   localparam coord_type CMIN = 32'sh80000000;

   initial begin
      for (int i = 0; i < N_DIRECTED; i++) typed_valid[i] = 1'b0;
      // clean cross at the middle of both
      pair_table[0] = pack_pair(0, 0, 4, 4, 0, 4, 4, 0);
      typed_table[0] = {1'b1, 17'd32768, 17'd32768, 32'sd2, 32'sd2}; typed_valid[0] = 1'b1;
      // parallel
      pair_table[1] = pack_pair(0, 0, 4, 0, 0, 1, 4, 1);
      typed_table[1] = '0; typed_valid[1] = 1'b1;
      // collinear overlapping
      pair_table[2] = pack_pair(0, 0, 4, 0, 2, 0, 6, 0);
      typed_table[2] = '0; typed_valid[2] = 1'b1;
      // touching at start of both
      pair_table[3] = pack_pair(0, 0, 4, 0, 0, 0, 0, 4);
      typed_table[3] = {1'b1, 17'd0, 17'd0, 32'sd0, 32'sd0}; typed_valid[3] = 1'b1;
      // touching at end of first
      pair_table[4] = pack_pair(0, 0, 4, 0, 4, -2, 4, 2);
      typed_table[4] = {1'b1, 17'd65536, 17'd32768, 32'sd4, 32'sd0}; typed_valid[4] = 1'b1;
      // zero-length segment
      pair_table[5] = pack_pair(3, 3, 3, 3, 0, 0, 6, 6);
      typed_table[5] = '0; typed_valid[5] = 1'b1;
      // miss beyond the end
      pair_table[6] = pack_pair(0, 0, 1, 1, 5, 0, 5, 9);
      typed_table[6] = '0; typed_valid[6] = 1'b1;
      pair_table[7] = pack_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
      pair_table[8] = pack_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
      pair_table[9] = pack_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
      pair_table[10] = pack_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
      pair_table[11] = '1;
      pair_table[12] = '0;
      pair_table[13] = pack_pair(-7, 3, 5, -9, -1, -8, 2, 6);
      pair_table[14] = pack_pair(CMIN, CMIN, CMIN, CMAX, CMIN, 0, CMAX, 5);
      pair_table[15] = pack_pair(1, -1, -3, 7, CMAX, CMAX, CMIN, CMIN);
   end

   // sender
   initial begin
      logic [RQW-1:0] w;
      int gap;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
         if (i < N_DIRECTED) w = pair_table[i];
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: w = crossing_pair(1000);
               4, 5: w = crossing_pair(1 << $urandom_range(1, 29));
               6: w = pack_pair(rand_coord(3), rand_coord(3), rand_coord(3), rand_coord(3),
                                rand_coord(3), rand_coord(3), rand_coord(3), rand_coord(3));
               7: w = pack_pair(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                                rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
               default: begin
                  for (int k = 0; k < 8; k++) w[k*CB +: CB] = rand_coord(0);
               end
            endcase
         end
         if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= w;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (i < N_DIRECTED && typed_valid[i])
            expected_q.insert(expected_q.size(), typed_table[i]);
         else
            expected_q.insert(expected_q.size(), predict_crossing(w));
         if (i > N_DIRECTED + N_RANDOM - 80) calm = 1'b1;
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // long receiver hold-off so the pipe fills and backs up the input
   initial begin
      wait (cycles > 300);
      hold_rsp = 1'b1;
      repeat (120) @(posedge clock);
      hold_rsp = 1'b0;
      pressure_done = 1'b1;
   end

   // receiver
   initial begin
      int gap;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // checker samples at the edge, before the driving processes update
   always @(posedge clock) begin
      crossing_type want;
      logic [PW-1:0] g1, g2;
      coord_type gx, gy;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g1 = rsp_tdata[0 +: PW];
         g2 = rsp_tdata[PW +: PW];
         gx = rsp_tdata[2*PW +: CB];
         gy = rsp_tdata[2*PW+CB +: CB];
         if (expected_q.size() == 0) report("unexpected word", rsp_tdata[63:0], '0);
         else begin
            want = expected_q.pop_front();
            if (rsp_tuser !== want.hit) report("hit", 64'(rsp_tuser), 64'(want.hit));
            if (g1 !== want.t1) report("first_param", 64'(g1), 64'(want.t1));
            if (g2 !== want.t2) report("second_param", 64'(g2), 64'(want.t2));
            if (gx !== want.cx) report("cross_x", 64'(gx), 64'(want.cx));
            if (gy !== want.cy) report("cross_y", 64'(gy), 64'(want.cy));
         end
      end
   end

   initial begin
      wait (sending_done && pressure_done);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/spi_pkg.sv
rtl/core/spi_front.sv
rtl/core/spi_queue.sv
rtl/core/spi_back.sv
rtl/core/segment_pair_intersect.sv
dv/tb_segment_pair_intersect.sv
